// ----- src/touch_gesture_classifier_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Touch gesture classifier: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef TOUCH_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH
`define TOUCH_GESTURE_CLASSIFIER_UNIT_DEFINES_SVH

// Same-cycle implication
`define TGC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tgc assertion failed");

// Next-cycle implication
`define TGC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tgc assertion failed");

`endif

// ----- src/tgc_pkg.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier package
// Screen geometry, register indexes, gesture codes and shared types.
// ---------------------------------------------------------------------------
`default_nettype none

package tgc_pkg;

  // Screen and raw panel geometry
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int RAW_WIDTH     = 240;
  localparam int RAW_HEIGHT    = 320;

  // Signed width for rotate/mirror arithmetic on 12-bit raw points
  localparam int CALC_W = 14;

  // Classification constants
  localparam int SWIPE_MARGIN = 8;
  localparam int TAP_MIN_MS   = 12;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [2:0] CFG_ROTATION   = 3'd0;
  localparam logic [2:0] CFG_FLIP_X     = 3'd1;
  localparam logic [2:0] CFG_FLIP_Y     = 3'd2;
  localparam logic [2:0] CFG_SWIPE_MIN  = 3'd3;
  localparam logic [2:0] CFG_TAP_MOVE   = 3'd4;
  localparam logic [2:0] CFG_LONG_PRESS = 3'd5;

  // Rotation codes (others are identity)
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef enum logic [2:0] {
    GEST_NONE        = 3'd0,
    GEST_TAP         = 3'd1,
    GEST_LONG_PRESS  = 3'd2,
    GEST_SWIPE_LEFT  = 3'd3,
    GEST_SWIPE_RIGHT = 3'd4,
    GEST_SWIPE_UP    = 3'd5,
    GEST_SWIPE_DOWN  = 3'd6
  } gesture_e;

  typedef struct packed {
    logic [1:0]  rotation;
    logic        flip_x;
    logic        flip_y;
    logic [8:0]  swipe_min;
    logic [8:0]  tap_move_max;
    logic [15:0] long_press_ms;
  } cfg_t;

  // Decoded poll handed from front to back
  typedef struct packed {
    logic        touch;
    logic [8:0]  x;
    logic [7:0]  y;
    logic [31:0] now_ms;
  } poll_t;

  // Queue handshake status toward the back end
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage

`default_nettype wire

// ----- src/tgc_front.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier front end
// Qualifies a poll as touch or release and maps the raw point to the screen.
// ---------------------------------------------------------------------------
`default_nettype none

module tgc_front
  import tgc_pkg::*;
(
  input  var cfg_t       cfg_i,
  input  var logic       read_ok_i,
  input  var logic [7:0] touch_status_i,
  input  var logic [7:0] x_high_i,
  input  var logic [7:0] x_low_i,
  input  var logic [7:0] y_high_i,
  input  var logic [7:0] y_low_i,
  input  var logic [31:0] now_ms_i,
  output poll_t          poll_o
);

  localparam logic signed [CALC_W-1:0] RawHm1 = CALC_W'(RAW_HEIGHT - 1);
  localparam logic signed [CALC_W-1:0] RawWm1 = CALC_W'(RAW_WIDTH - 1);
  localparam logic signed [CALC_W-1:0] ScrW   = CALC_W'(SCREEN_WIDTH);
  localparam logic signed [CALC_W-1:0] ScrH   = CALC_W'(SCREEN_HEIGHT);
  localparam logic signed [CALC_W-1:0] ScrWm1 = CALC_W'(SCREEN_WIDTH - 1);
  localparam logic signed [CALC_W-1:0] ScrHm1 = CALC_W'(SCREEN_HEIGHT - 1);

  logic signed [CALC_W-1:0] rx, ry, sx, sy, fx, fy, cx, cy;
  logic touch;

  // Saturate one axis to [0, size-1]
  function automatic logic signed [CALC_W-1:0] clamp_axis(
    input logic signed [CALC_W-1:0] v,
    input logic signed [CALC_W-1:0] size
  );
    logic signed [CALC_W-1:0] r;
    if (v[CALC_W-1]) begin
      r = '0;
    end else if (v >= size) begin
      r = size - CALC_W'(1);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign touch = read_ok_i && (touch_status_i[3:0] != 4'd0);
  assign rx = {2'b00, x_high_i[3:0], x_low_i};
  assign ry = {2'b00, y_high_i[3:0], y_low_i};

  // Rotation
  always_comb begin
    case (cfg_i.rotation)
      ROT_90: begin
        sx = RawHm1 - ry;
        sy = rx;
      end
      ROT_270: begin
        sx = ry;
        sy = RawWm1 - rx;
      end
      default: begin
        sx = rx;
        sy = ry;
      end
    endcase
  end

  // Mirror and clamp
  assign fx = cfg_i.flip_x ? (ScrWm1 - sx) : sx;
  assign fy = cfg_i.flip_y ? (ScrHm1 - sy) : sy;
  assign cx = clamp_axis(fx, ScrW);
  assign cy = clamp_axis(fy, ScrH);

  // No touch carries a zero point
  assign poll_o.touch  = touch;
  assign poll_o.x      = touch ? cx[8:0] : 9'd0;
  assign poll_o.y      = touch ? cy[7:0] : 8'd0;
  assign poll_o.now_ms = now_ms_i;

endmodule

`default_nettype wire

// ----- src/tgc_queue.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier queue
// Short register FIFO that decouples the front end from the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module tgc_queue
  import tgc_pkg::*;
(
  input  var logic  clk_i,
  input  var logic  rst_ni,
  input  var logic  push_i,
  input  var poll_t push_data_i,
  input  var logic  pop_i,
  output poll_t     pop_data_o,
  output qstat_t    stat_o
);

  poll_t entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic do_push, do_pop;

  assign stat_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.valid = (count_q != '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && stat_o.valid;

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o = entry_q[rd_ptr_q];

endmodule

`default_nettype wire

// ----- src/tgc_back.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier back end
// Tracks the press and classifies it on release; holds the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tgc_back
  import tgc_pkg::*;
(
  input  var logic   clk_i,
  input  var logic   rst_ni,
  input  var cfg_t   cfg_i,
  input  var qstat_t qstat_i,
  input  var poll_t  poll_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  var logic   out_stall_i,
  output logic [2:0] gesture_o,
  output logic [8:0] tap_x_o,
  output logic [7:0] tap_y_o,
  output logic       touching_o,
  output logic [8:0] touch_x_o,
  output logic [7:0] touch_y_o,
  output logic       swiping_o
);

  // Press state
  logic        pressed_q, pressed_d;
  logic [31:0] press_time_q, press_time_d;
  logic [8:0]  start_x_q, start_x_d, last_x_q, last_x_d;
  logic [7:0]  start_y_q, start_y_d, last_y_q, last_y_d;
  logic        swipe_seen_q, swipe_seen_d;

  // Result register
  logic        out_valid_q;
  gesture_e    gesture_q, gesture_d;
  logic [8:0]  tap_x_q, tap_x_d, touch_x_q;
  logic [7:0]  tap_y_q, tap_y_d, touch_y_q;
  logic        touching_q;
  logic        swiping_q;

  // Working values
  logic [8:0]  mv_dx, rel_dx;
  logic [7:0]  mv_dy, rel_dy;
  logic [31:0] dur;
  logic        h_swipe, v_swipe, tap_ok, long_ok;

  assign pop_o = qstat_i.valid && (!out_valid_q || !out_stall_i);

  // Travel while pressed, against the start of this press
  always_comb begin
    start_x_d    = pressed_q ? start_x_q : poll_i.x;
    start_y_d    = pressed_q ? start_y_q : poll_i.y;
    mv_dx = (poll_i.x >= start_x_d) ? poll_i.x - start_x_d : start_x_d - poll_i.x;
    mv_dy = (poll_i.y >= start_y_d) ? poll_i.y - start_y_d : start_y_d - poll_i.y;
  end

  // Release travel and hold time
  assign rel_dx = (last_x_q >= start_x_q) ? last_x_q - start_x_q : start_x_q - last_x_q;
  assign rel_dy = (last_y_q >= start_y_q) ? last_y_q - start_y_q : start_y_q - last_y_q;
  assign dur    = poll_i.now_ms - press_time_q;

  assign h_swipe = (rel_dx >= cfg_i.swipe_min) &&
                   ({1'b0, rel_dx} > ({2'b00, rel_dy} + 10'(SWIPE_MARGIN)));
  assign v_swipe = ({1'b0, rel_dy} >= cfg_i.swipe_min) &&
                   ({2'b00, rel_dy} > ({1'b0, rel_dx} + 10'(SWIPE_MARGIN)));
  assign long_ok = (dur >= {16'd0, cfg_i.long_press_ms});
  assign tap_ok  = (dur >= 32'(TAP_MIN_MS)) && !long_ok &&
                   (rel_dx <= cfg_i.tap_move_max) &&
                   ({1'b0, rel_dy} <= cfg_i.tap_move_max);

  // Next state and result
  always_comb begin
    pressed_d    = pressed_q;
    press_time_d = press_time_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    swipe_seen_d = swipe_seen_q;
    gesture_d    = GEST_NONE;
    tap_x_d      = '0;
    tap_y_d      = '0;
    if (poll_i.touch) begin
      pressed_d    = 1'b1;
      press_time_d = pressed_q ? press_time_q : poll_i.now_ms;
      last_x_d     = poll_i.x;
      last_y_d     = poll_i.y;
      swipe_seen_d = (pressed_q && swipe_seen_q) ||
                     ((mv_dx >= cfg_i.swipe_min) && (mv_dx > {1'b0, mv_dy}));
    end else if (pressed_q) begin
      pressed_d    = 1'b0;
      swipe_seen_d = 1'b0;
      if (h_swipe) begin
        gesture_d = (last_x_q < start_x_q) ? GEST_SWIPE_LEFT : GEST_SWIPE_RIGHT;
      end else if (v_swipe) begin
        gesture_d = (last_y_q < start_y_q) ? GEST_SWIPE_UP : GEST_SWIPE_DOWN;
      end else if (tap_ok) begin
        gesture_d = GEST_TAP;
        tap_x_d   = last_x_q;
        tap_y_d   = last_y_q;
      end else if (long_ok) begin
        gesture_d = GEST_LONG_PRESS;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pressed_q    <= 1'b0;
      press_time_q <= '0;
      start_x_q    <= '0;
      start_y_q    <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      swipe_seen_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        pressed_q    <= pressed_d;
        press_time_q <= press_time_d;
        if (poll_i.touch) begin
          start_x_q <= start_x_d;
          start_y_q <= start_y_d;
        end
        last_x_q     <= last_x_d;
        last_y_q     <= last_y_d;
        swipe_seen_q <= swipe_seen_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      gesture_q  <= gesture_d;
      tap_x_q    <= tap_x_d;
      tap_y_q    <= tap_y_d;
      touching_q <= poll_i.touch;
      touch_x_q  <= poll_i.x;
      touch_y_q  <= poll_i.y;
      swiping_q  <= poll_i.touch && swipe_seen_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign gesture_o   = gesture_q;
  assign tap_x_o     = tap_x_q;
  assign tap_y_o     = tap_y_q;
  assign touching_o  = touching_q;
  assign touch_x_o   = touch_x_q;
  assign touch_y_o   = touch_y_q;
  assign swiping_o   = swiping_q;

endmodule

`default_nettype wire

// ----- src/touch_gesture_classifier_unit.sv -----
// ---------------------------------------------------------------------------
// Touch gesture classifier unit
// Maps touch polls to screen points and reports tap, long press and swipes.
//
//   channel  handshake              payload
//   in       in_valid_i/in_stall_o  read_ok, status, x/y bytes, now_ms
//   out      out_valid_o/out_stall_i gesture, tap point, touch point, swiping
//   cfg      cfg_we_i               cfg_index_i, cfg_data_i
//
// One poll per cycle sustained while out_stall_i is low; the back end
// updates the press state with each poll it pops. A poll enters the
// two-entry queue, then the back end writes the result register.
// Reset restores register defaults and clears the press state and queue.
// Output stalls fill the queue; in_stall_o rises when it holds two polls.
// ---------------------------------------------------------------------------
`default_nettype none

`include "touch_gesture_classifier_unit_defines.svh"

module touch_gesture_classifier_unit
  import tgc_pkg::*;
(
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        cfg_we_i,
  input  var logic [2:0]  cfg_index_i,
  input  var logic [15:0] cfg_data_i,
  input  var logic        in_valid_i,
  output logic            in_stall_o,
  input  var logic        read_ok_i,
  input  var logic [7:0]  touch_status_i,
  input  var logic [7:0]  x_high_i,
  input  var logic [7:0]  x_low_i,
  input  var logic [7:0]  y_high_i,
  input  var logic [7:0]  y_low_i,
  input  var logic [31:0] now_ms_i,
  output logic            out_valid_o,
  input  var logic        out_stall_i,
  output logic [2:0]      gesture_o,
  output logic [8:0]      tap_x_o,
  output logic [7:0]      tap_y_o,
  output logic            touching_o,
  output logic [8:0]      touch_x_o,
  output logic [7:0]      touch_y_o,
  output logic            swiping_o
);

  cfg_t   cfg_q;
  poll_t  front_poll, head_poll;
  qstat_t qstat;
  logic   pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rotation      <= 2'd0;
      cfg_q.flip_x        <= 1'b0;
      cfg_q.flip_y        <= 1'b0;
      cfg_q.swipe_min     <= 9'd40;
      cfg_q.tap_move_max  <= 9'd16;
      cfg_q.long_press_ms <= 16'd1000;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ROTATION:   cfg_q.rotation      <= cfg_data_i[1:0];
        CFG_FLIP_X:     cfg_q.flip_x        <= cfg_data_i[0];
        CFG_FLIP_Y:     cfg_q.flip_y        <= cfg_data_i[0];
        CFG_SWIPE_MIN:  cfg_q.swipe_min     <= cfg_data_i[8:0];
        CFG_TAP_MOVE:   cfg_q.tap_move_max  <= cfg_data_i[8:0];
        CFG_LONG_PRESS: cfg_q.long_press_ms <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tgc_front u_front (
    .cfg_i          (cfg_q),
    .read_ok_i      (read_ok_i),
    .touch_status_i (touch_status_i),
    .x_high_i       (x_high_i),
    .x_low_i        (x_low_i),
    .y_high_i       (y_high_i),
    .y_low_i        (y_low_i),
    .now_ms_i       (now_ms_i),
    .poll_o         (front_poll)
  );

  assign in_stall_o = qstat.full;

  tgc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_i),
    .push_data_i (front_poll),
    .pop_i       (pop),
    .pop_data_o  (head_poll),
    .stat_o      (qstat)
  );

  tgc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .qstat_i     (qstat),
    .poll_i      (head_poll),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .gesture_o   (gesture_o),
    .tap_x_o     (tap_x_o),
    .tap_y_o     (tap_y_o),
    .touching_o  (touching_o),
    .touch_x_o   (touch_x_o),
    .touch_y_o   (touch_y_o),
    .swiping_o   (swiping_o)
  );

  // A gesture is only reported on a release poll
  `TGC_ASSERT_IMP(a_gesture_on_release, out_valid_o && (gesture_o != GEST_NONE), !touching_o)
  // Release results carry no touch point and no swiping flag
  `TGC_ASSERT_IMP(a_release_clean, out_valid_o && !touching_o,
                  (touch_x_o == 9'd0) && (touch_y_o == 8'd0) && !swiping_o)
  // Back end drains the queue whenever the result register is free
  `TGC_ASSERT_NXT(a_queue_drains, qstat.valid && !out_valid_o, out_valid_o)

endmodule

`default_nettype wire
